// ===== src/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg: shared types and constants of the glob matcher
// Command codes, pattern capacity, row type and the prefix network used for
// star runs and for the empty-text row.
// ----------------------------------------------------------------------------
package wgm_pkg;

   localparam int PATTERN_MAX = 32;
   localparam int RowWidth    = PATTERN_MAX + 1;
   localparam int LenWidth    = $clog2(PATTERN_MAX + 1);
   localparam int PrefixLevels = $clog2(RowWidth);

   localparam logic [7:0] STAR_BYTE = 8'd42;
   localparam logic [7:0] ANY_BYTE  = 8'd63;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_START  = 2'd2,
      CMD_TEXT   = 2'd3
   } command_type;

   typedef logic [7:0]          byte_type;
   typedef logic [RowWidth-1:0] row_type;
   typedef logic [LenWidth-1:0] len_type;

   // Parallel prefix: out[j] = gen[j] | prop[j] & out[j-1], log-depth.
   function automatic row_type prefix_carry(row_type gen, row_type prop);
      row_type g;
      row_type p;
      row_type g_nxt;
      row_type p_nxt;
      int      span;
      g = gen;
      p = prop;
      for (int lvl = 0; lvl < PrefixLevels; lvl++) begin
         span  = 1 << lvl;
         g_nxt = g;
         p_nxt = p;
         for (int j = 0; j < RowWidth; j++) begin
            if (j >= span) begin
               g_nxt[j] = g[j] | (p[j] & g[j - span]);
               p_nxt[j] = p[j] & p[j - span];
            end
         end
         g = g_nxt;
         p = p_nxt;
      end
      return g;
   endfunction

   // Ones in bits 0..len, zero above.
   function automatic row_type length_mask(len_type len);
      row_type m;
      for (int j = 0; j < RowWidth; j++) begin
         m[j] = (LenWidth'(j) <= len);
      end
      return m;
   endfunction

endpackage

// ===== src/wgm_req_if.sv =====
// ----------------------------------------------------------------------------
// wgm_req_if: command channel of the glob matcher
// Valid/ready channel carrying one command and its byte per item.
// ----------------------------------------------------------------------------
interface wgm_req_if;
   import wgm_pkg::*;

   logic        valid;
   logic        ready;
   command_type command;
   byte_type    char_byte;

   modport source (output valid, output command, output char_byte, input ready);
   modport sink   (input valid, input command, input char_byte, output ready);
endinterface

// ===== src/wgm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wgm_rsp_if: result channel of the glob matcher
// Valid/ready channel carrying the match flag and status per item.
// ----------------------------------------------------------------------------
interface wgm_rsp_if;
   logic valid;
   logic ready;
   logic full_match;
   logic status;

   modport source (output valid, output full_match, output status, input ready);
   modport sink   (input valid, input full_match, input status, output ready);
endinterface

// ===== src/wildcard_glob_matcher_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_core: streaming whole-text glob matcher
// Loads a pattern with '*' and '?' byte by byte and matches streamed text
// against it with one bit-parallel dynamic-programming row.
// ----------------------------------------------------------------------------
// Every command item (clear pattern, append pattern byte, start text, text
// byte) yields exactly one result item in the cycle after it is accepted,
// telling whether the text so far matches the whole pattern, plus a status
// bit that flags an append dropped because the 32-byte store is full. The
// block takes one item per cycle: the pattern store, length and match row
// update at the accept edge through a single pass of per-position compares
// and a log-depth prefix network for star runs, and the result sits in an
// output register, so a new item is taken while the last result waits as
// long as the result side takes it in the same cycle. An append that is
// stored restarts the text as empty.
module wildcard_glob_matcher_core (
   input logic   clock,
   input logic   reset,
   wgm_req_if.sink   req_chan,
   wgm_rsp_if.source rsp_chan
);
   import wgm_pkg::*;

   byte_type             store_ff [PATTERN_MAX];
   byte_type             store_in [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] star_ff;
   logic [PATTERN_MAX-1:0] star_in;
   len_type              len_ff;
   len_type              len_in;
   row_type              row_ff;
   row_type              row_in;
   logic                 rsp_valid_ff;
   logic                 match_ff;
   logic                 status_ff;
   logic                 status_in;

   logic    accept;
   logic    store_full;
   logic    do_append;
   row_type text_gen;
   row_type text_prop;
   row_type empty_gen;
   row_type empty_prop;
   row_type text_row;
   row_type empty_row;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign store_full     = (len_ff == LenWidth'(PATTERN_MAX));
   assign do_append      = (req_chan.command == CMD_APPEND) && !store_full;

   // Pattern store and star flags after this item.
   always_comb begin
      store_in = store_ff;
      star_in  = star_ff;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (do_append && len_ff == LenWidth'(i)) begin
            store_in[i] = req_chan.char_byte;
            star_in[i]  = (req_chan.char_byte == STAR_BYTE);
         end
      end
   end

   // One text byte: literal/any positions take the diagonal, star runs
   // propagate rightward through the prefix network.
   always_comb begin
      text_gen  = '0;
      text_prop = '0;
      for (int j = 1; j < RowWidth; j++) begin
         text_prop[j] = star_ff[j-1];
         if (star_ff[j-1]) begin
            text_gen[j] = row_ff[j];
         end else begin
            text_gen[j] = row_ff[j-1] && (store_ff[j-1] == ANY_BYTE ||
                                          store_ff[j-1] == req_chan.char_byte);
         end
      end
      text_row = prefix_carry(text_gen, text_prop) & length_mask(len_ff);
   end

   // Empty text: bit j set when the first j pattern bytes are all stars.
   always_comb begin
      empty_gen     = '0;
      empty_gen[0]  = 1'b1;
      empty_prop    = '0;
      for (int j = 1; j < RowWidth; j++) begin
         empty_prop[j] = star_in[j-1];
      end
      empty_row = prefix_carry(empty_gen, empty_prop) & length_mask(len_in);
   end

   always_comb begin
      len_in    = len_ff;
      row_in    = row_ff;
      status_in = 1'b0;
      unique case (req_chan.command)
         CMD_CLEAR: begin
            len_in = '0;
            row_in = empty_row;
         end
         CMD_APPEND: begin
            if (store_full) begin
               status_in = 1'b1;
            end else begin
               len_in = len_ff + len_type'(1);
               row_in = empty_row;
            end
         end
         CMD_START: begin
            row_in = empty_row;
         end
         CMD_TEXT: begin
            row_in = text_row;
         end
         default: begin
            row_in = row_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         row_ff       <= row_type'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            len_ff       <= len_in;
            row_ff       <= row_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: store and result hold until the next accepted item.
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff  <= store_in;
         star_ff   <= star_in;
         match_ff  <= row_in[len_in];
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.full_match = match_ff;
   assign rsp_chan.status     = status_ff;

endmodule
